/* rtl/core/lcdws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types and constants of the character LCD write sequencer: request
// and response payloads, queued command words, register set and the control
// and status groups between the sequencer and its word queue.
// ----------------------------------------------------------------------------
package lcdws_pkg;

    // default queue depth in words
    localparam int LCDWS_FIFO_DEPTH = 16;

    // configuration port address width (six registers at 4-byte spacing)
    localparam int LCDWS_ADDR_W = 5;

    // request codes
    localparam logic LCDWS_CMD_ENQUEUE = 1'b0;
    localparam logic LCDWS_CMD_TICK    = 1'b1;

    // word flag bit positions
    localparam int LCDWS_FLAG_CMD        = 7;
    localparam int LCDWS_FLAG_SCROLL_ON  = 6;
    localparam int LCDWS_FLAG_SCROLL_OFF = 5;

    // register indexes, one 32-bit word each
    typedef enum logic [2:0] {
        REG_SHORT_WAIT  = 3'd0,
        REG_SETUP_WAIT  = 3'd1,
        REG_ENABLE_WAIT = 3'd2,
        REG_HOLD_WAIT   = 3'd3,
        REG_TICKS_MS    = 3'd4,
        REG_SCROLL_BYTE = 3'd5
    } lcdws_reg_idx_t;

    // incoming request: enqueue a word or advance one tick
    typedef struct packed {
        logic        command;
        logic [7:0]  bus_byte;
        logic [7:0]  word_flags;
        logic [14:0] delay_ms;
    } lcdws_req_t;

    // response: pin levels and status after the request
    typedef struct packed {
        logic       rs_level;
        logic       rw_level;
        logic       enable_level;
        logic [7:0] data_bus;
        logic       busy_res;
        logic       dropped;
    } lcdws_rsp_t;

    // one queued command word
    typedef struct packed {
        logic [14:0] delay_ms;
        logic [7:0]  word_flags;
        logic [7:0]  bus_byte;
    } lcdws_word_t;

    // configuration register set
    typedef struct packed {
        logic [15:0] short_wait_ticks;
        logic [15:0] setup_wait_ticks;
        logic [15:0] enable_wait_ticks;
        logic [15:0] hold_wait_ticks;
        logic [15:0] ticks_per_ms;
        logic [7:0]  scroll_shift_byte;
    } lcdws_cfg_t;

    // queue control from the sequencer
    typedef struct packed {
        logic        push;
        logic        pop;
        lcdws_word_t word;
    } lcdws_fifo_req_t;

    // queue status back to the sequencer
    typedef struct packed {
        logic        empty;
        logic        full;
        lcdws_word_t head_word;
    } lcdws_fifo_sts_t;

endpackage

/* rtl/core/lcdws_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_cfg
// APB-style register file holding the wait counts, the tick scale for word
// delays and the display shift byte.
// ----------------------------------------------------------------------------
module lcdws_cfg
    import lcdws_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [LCDWS_ADDR_W-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output lcdws_cfg_t              cfg
);

    localparam logic [15:0] RST_SHORT_WAIT  = 16'd16;
    localparam logic [15:0] RST_SETUP_WAIT  = 16'd10;
    localparam logic [15:0] RST_ENABLE_WAIT = 16'd40;
    localparam logic [15:0] RST_HOLD_WAIT   = 16'd7000;
    localparam logic [15:0] RST_TICKS_MS    = 16'd1000;
    localparam logic [7:0]  RST_SCROLL_BYTE = 8'd24;

    lcdws_reg_idx_t idx;
    logic           wr_en;
    lcdws_cfg_t     cfg_reg;

    // word index and write strobe
    assign idx    = lcdws_reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_wait_ticks  <= RST_SHORT_WAIT;
            cfg_reg.setup_wait_ticks  <= RST_SETUP_WAIT;
            cfg_reg.enable_wait_ticks <= RST_ENABLE_WAIT;
            cfg_reg.hold_wait_ticks   <= RST_HOLD_WAIT;
            cfg_reg.ticks_per_ms      <= RST_TICKS_MS;
            cfg_reg.scroll_shift_byte <= RST_SCROLL_BYTE;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SHORT_WAIT:  cfg_reg.short_wait_ticks  <= pwdata[15:0];
                REG_SETUP_WAIT:  cfg_reg.setup_wait_ticks  <= pwdata[15:0];
                REG_ENABLE_WAIT: cfg_reg.enable_wait_ticks <= pwdata[15:0];
                REG_HOLD_WAIT:   cfg_reg.hold_wait_ticks   <= pwdata[15:0];
                REG_TICKS_MS:    cfg_reg.ticks_per_ms      <= pwdata[15:0];
                REG_SCROLL_BYTE: cfg_reg.scroll_shift_byte <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (idx)
            REG_SHORT_WAIT:  prdata = {16'b0, cfg_reg.short_wait_ticks};
            REG_SETUP_WAIT:  prdata = {16'b0, cfg_reg.setup_wait_ticks};
            REG_ENABLE_WAIT: prdata = {16'b0, cfg_reg.enable_wait_ticks};
            REG_HOLD_WAIT:   prdata = {16'b0, cfg_reg.hold_wait_ticks};
            REG_TICKS_MS:    prdata = {16'b0, cfg_reg.ticks_per_ms};
            REG_SCROLL_BYTE: prdata = {24'b0, cfg_reg.scroll_shift_byte};
            default:         prdata = 32'b0;
        endcase
    end

endmodule

/* rtl/core/lcdws_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_fifo
// Command word queue. Words sit in a memory; the word at the head is read
// ahead into a register, with bypass of a write to that slot.
// ----------------------------------------------------------------------------
module lcdws_fifo
    import lcdws_pkg::*;
#(
    parameter int FIFO_DEPTH = LCDWS_FIFO_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  lcdws_fifo_req_t req,
    output lcdws_fifo_sts_t sts
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

    lcdws_word_t      mem [FIFO_DEPTH];
    lcdws_word_t      head_word_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    // pointer and count update
    always_comb
    begin
        head_next  = req.pop  ? ptr_inc(head_reg) : head_reg;
        tail_next  = req.push ? ptr_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (req.push && !req.pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!req.push && req.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // word storage and registered head read with write bypass
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[tail_reg] <= req.word;
        end
        if (req.push && (tail_reg == head_next))
        begin
            head_word_reg <= req.word;
        end
        else
        begin
            head_word_reg <= mem[head_next];
        end
    end

    // status
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == FULL_CNT);
    assign sts.head_word = head_word_reg;

    // fill level stays within the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    // no write into a full queue unless a word leaves at the same time
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (req.push && !req.pop) |-> !sts.full)
        else $error("push into full queue");

    // no read from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        req.pop |-> !sts.empty)
        else $error("pop from empty queue");

endmodule

/* rtl/core/lcdws_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_ctrl
// Paced write sequencer. Applies one request per cycle while go is high:
// enqueue or tick; stage machine, wait counter, scroll mode, pin levels.
// ----------------------------------------------------------------------------
module lcdws_ctrl
    import lcdws_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  lcdws_req_t      req,
    input  lcdws_cfg_t      cfg,
    input  lcdws_fifo_sts_t fsts,
    output lcdws_fifo_req_t freq,
    output lcdws_rsp_t      rsp_next
);

    typedef enum logic [2:0] {
        STG_FETCH  = 3'd0,
        STG_SETUP  = 3'd1,
        STG_ENABLE = 3'd2,
        STG_HOLD   = 3'd3,
        STG_FINISH = 3'd4
    } stage_t;

    localparam logic [7:0] REQUEUE_FLAGS  = 8'h80;
    localparam int         WAIT_W         = 31;

    stage_t            stage_reg, stage_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic              running_reg, running_next;
    logic              scroll_reg, scroll_next;
    logic [7:0]        held_byte_reg, held_byte_next;
    logic              held_cmd_reg, held_cmd_next;
    logic              rs_reg, rs_next;
    logic              en_reg, en_next;
    logic [7:0]        data_reg, data_next;
    logic              dropped;
    lcdws_word_t       hw;
    logic [WAIT_W-1:0] short_ticks;
    logic [WAIT_W-1:0] delay_ticks;
    stage_t            after_fetch;

    // zero tick count acts as one
    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == '0) ? 16'd1 : v;
    endfunction

    assign hw          = fsts.head_word;
    assign short_ticks = WAIT_W'(at_least_one(cfg.short_wait_ticks));
    assign delay_ticks = {16'b0, hw.delay_ms} *
                         {15'b0, at_least_one(cfg.ticks_per_ms)};

    // next state for one request
    always_comb
    begin
        stage_next     = stage_reg;
        wait_next      = wait_reg;
        running_next   = running_reg;
        scroll_next    = scroll_reg;
        held_byte_next = held_byte_reg;
        held_cmd_next  = held_cmd_reg;
        rs_next        = rs_reg;
        en_next        = en_reg;
        data_next      = data_reg;
        dropped        = 1'b0;
        after_fetch    = STG_SETUP;
        freq.push      = 1'b0;
        freq.pop       = 1'b0;
        freq.word      = {req.delay_ms, req.word_flags, req.bus_byte};

        if (go)
        begin
            if (req.command == LCDWS_CMD_ENQUEUE)
            begin
                // enqueue: store the word, start the machine when idle
                if (fsts.full)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    freq.push = 1'b1;
                    if (!running_reg)
                    begin
                        running_next = 1'b1;
                        stage_next   = STG_FETCH;
                        wait_next    = short_ticks;
                    end
                end
            end
            else if (running_reg)
            begin
                if (wait_reg > WAIT_W'(1))
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
                else
                begin
                    case (stage_reg)
                        STG_FETCH:
                        begin
                            wait_next = short_ticks;
                            if (fsts.empty)
                            begin
                                stage_next = STG_FINISH;
                            end
                            else
                            begin
                                freq.pop       = 1'b1;
                                held_byte_next = hw.bus_byte;
                                held_cmd_next  = hw.word_flags[LCDWS_FLAG_CMD];
                                if (hw.word_flags[LCDWS_FLAG_SCROLL_ON])
                                begin
                                    scroll_next = 1'b1;
                                    stage_next  = STG_FINISH;
                                end
                                else if (hw.word_flags[LCDWS_FLAG_SCROLL_OFF])
                                begin
                                    scroll_next = 1'b0;
                                    stage_next  = STG_FINISH;
                                end
                                else
                                begin
                                    // shift word: re-queue while scrolling, else skip
                                    if (hw.bus_byte == cfg.scroll_shift_byte)
                                    begin
                                        if (scroll_reg)
                                        begin
                                            freq.push = 1'b1;
                                            freq.word = {hw.delay_ms, REQUEUE_FLAGS,
                                                         hw.bus_byte};
                                        end
                                        else
                                        begin
                                            after_fetch = STG_FINISH;
                                        end
                                    end
                                    if (hw.delay_ms != '0)
                                    begin
                                        wait_next = delay_ticks;
                                    end
                                    stage_next = after_fetch;
                                end
                            end
                        end
                        STG_SETUP:
                        begin
                            rs_next    = !held_cmd_reg;
                            wait_next  = WAIT_W'(at_least_one(cfg.setup_wait_ticks));
                            stage_next = STG_ENABLE;
                        end
                        STG_ENABLE:
                        begin
                            en_next    = 1'b1;
                            data_next  = held_byte_reg;
                            wait_next  = WAIT_W'(at_least_one(cfg.enable_wait_ticks));
                            stage_next = STG_HOLD;
                        end
                        STG_HOLD:
                        begin
                            en_next    = 1'b0;
                            wait_next  = WAIT_W'(at_least_one(cfg.hold_wait_ticks));
                            stage_next = STG_FINISH;
                        end
                        default:
                        begin
                            // finish: fetch again or stop on an empty queue
                            stage_next = STG_FETCH;
                            if (fsts.empty)
                            begin
                                running_next = 1'b0;
                                wait_next    = '0;
                            end
                            else
                            begin
                                wait_next = short_ticks;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // state and pin registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= STG_FETCH;
            wait_reg      <= '0;
            running_reg   <= 1'b0;
            scroll_reg    <= 1'b0;
            held_byte_reg <= '0;
            held_cmd_reg  <= 1'b0;
            rs_reg        <= 1'b0;
            en_reg        <= 1'b0;
            data_reg      <= '0;
        end
        else
        begin
            stage_reg     <= stage_next;
            wait_reg      <= wait_next;
            running_reg   <= running_next;
            scroll_reg    <= scroll_next;
            held_byte_reg <= held_byte_next;
            held_cmd_reg  <= held_cmd_next;
            rs_reg        <= rs_next;
            en_reg        <= en_next;
            data_reg      <= data_next;
        end
    end

    // response for this request; read/write pin is always driven for write
    assign rsp_next.rs_level     = rs_next;
    assign rsp_next.rw_level     = 1'b0;
    assign rsp_next.enable_level = en_next;
    assign rsp_next.data_bus     = data_next;
    assign rsp_next.busy_res     = running_next;
    assign rsp_next.dropped      = dropped;

    // idle machine rests at fetch with a cleared counter
    a_idle_rest: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (stage_reg == STG_FETCH) && (wait_reg == '0))
        else $error("idle sequencer not parked");

    // a running machine always has a pending wait
    a_wait_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (wait_reg != '0))
        else $error("running with empty wait counter");

    // enable is high only while the hold stage is pending
    a_enable_stage: assert property (@(posedge clk) disable iff (!rst_n)
        en_reg |-> (stage_reg == STG_HOLD) && running_reg)
        else $error("enable high outside hold stage");

endmodule

/* rtl/core/char_lcd_write_sequencer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top
// Character LCD write sequencer: request register, sequencer, word queue,
// register file and response register.
// ----------------------------------------------------------------------------
// Each request either queues a command word or advances the write sequence by
// one timer tick, and produces exactly one response carrying the LCD pin
// levels, the busy flag and a drop flag for a word lost to a full queue. The
// block takes one request per clock while req_stall is low: a request is
// registered on acceptance and, once the response slot is free, applied to
// the sequencer state as its response is registered. A stalled response
// holds the request register, which then stalls the input. The path that
// bounds the clock is the head word read from the queue through the delay
// multiply (15 by 16 bits) into the wait counter. Delays and pulse widths
// are counted in ticks, not clocks. The queue holds FIFO_DEPTH words; the
// user must write registers only while no request or response is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_top
    import lcdws_pkg::*;
#(
    parameter int FIFO_DEPTH = LCDWS_FIFO_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  lcdws_req_t              req_data,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output lcdws_rsp_t              rsp_data,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [LCDWS_ADDR_W-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    lcdws_req_t      req_reg;
    logic            req_v_reg;
    lcdws_rsp_t      rsp_reg;
    logic            rsp_v_reg;
    logic            advance;
    logic            take;
    lcdws_cfg_t      cfg;
    lcdws_fifo_req_t freq;
    lcdws_fifo_sts_t fsts;
    lcdws_rsp_t      rsp_next;

    // a held request moves on when the response slot is free
    assign advance   = req_v_reg && (!rsp_v_reg || !rsp_stall);
    assign req_stall = req_v_reg && !advance;
    assign take      = req_valid && !req_stall;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_v_reg <= 1'b0;
        end
        else if (take)
        begin
            req_v_reg <= 1'b1;
        end
        else if (advance)
        begin
            req_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req_data;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_v_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_v_reg;
    assign rsp_data  = rsp_reg;

    // register file
    lcdws_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // word queue
    lcdws_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (freq),
        .sts   (fsts)
    );

    // sequencer
    lcdws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (advance),
        .req      (req_reg),
        .cfg      (cfg),
        .fsts     (fsts),
        .freq     (freq),
        .rsp_next (rsp_next)
    );

endmodule
